@@ rtl/mexp_pkg.sv @@
package mexp_pkg;

	localparam int WORD_BITS_DEF = 64;
	localparam int CFG_IDX_BITS = 2;

	localparam logic [CFG_IDX_BITS-1:0] REG_MODULUS = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_RECIP = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_SHIFT = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RED1,
		ST_RED2,
		ST_RED3,
		ST_NMUL,
		ST_INV_CHK,
		ST_INV_DIV,
		ST_INV_MUL,
		ST_INV_MOD,
		ST_EXP_START,
		ST_EXP_LOOP,
		ST_OUT
	} st_t;

	typedef enum logic [1:0] {
		RET_BASE,
		RET_ACC,
		RET_SQR
	} ret_t;

endpackage

@@ rtl/mexp_mul.sv @@
module mexp_mul #(
	parameter int WORD_BITS = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [WORD_BITS-1:0]   a,
	input  logic [WORD_BITS-1:0]   b,
	output logic                   done,
	output logic [2*WORD_BITS-1:0] prod
);
	localparam int W = WORD_BITS;
	localparam int H = (W + 1) / 2;

	logic [2*H-1:0] a_q, b_q;
	logic [4*H-1:0] acc_q;
	logic [1:0]     cnt_q;
	logic           busy_q, done_q;
	logic [H-1:0]   opa, opb;
	logic [2*H-1:0] pp;
	logic [1:0]     sh;
	logic [4*H-1:0] pp_sh;

	// Four half-width partial products are summed, one per cycle.
	always_comb begin
		opa = cnt_q[1] ? a_q[2*H-1:H] : a_q[H-1:0];
		opb = cnt_q[0] ? b_q[2*H-1:H] : b_q[H-1:0];
		pp = opa * opb;
		sh = 2'(cnt_q[1]) + 2'(cnt_q[0]);
		pp_sh = (4*H)'(pp) << (H * sh);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 2'd1;
			if (cnt_q == 2'd3) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= (2*H)'(a);
			b_q <= (2*H)'(b);
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_q + pp_sh;
		end
	end

	assign done = done_q;
	assign prod = acc_q[2*W-1:0];

endmodule

@@ rtl/mexp_div.sv @@
module mexp_div #(
	parameter int WORD_BITS = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [WORD_BITS-1:0] num,
	input  logic [WORD_BITS-1:0] den,
	output logic                 done,
	output logic [WORD_BITS-1:0] quot,
	output logic [WORD_BITS-1:0] rem
);
	localparam int W = WORD_BITS;
	localparam int CW = $clog2(W);

	logic [W-1:0]  quot_q, rem_q, den_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q, done_q;
	logic [W:0]    shv, trial;
	logic          ge;

	// Restoring division, one quotient bit per cycle.
	always_comb begin
		shv = {rem_q, quot_q[W-1]};
		trial = shv - {1'b0, den_q};
		ge = !trial[W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CW'(W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? trial[W-1:0] : shv[W-1:0];
			quot_q <= {quot_q[W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quot_q;
	assign rem = rem_q;

endmodule

@@ rtl/modular_exponentiation_unit.sv @@
// Modular exponentiation: result = base^exponent mod modulus.
// The configuration channel writes modulus, reciprocal and shift by index
// (0, 1, 2); it is always ready and should be used only while the block idles.
// The input channel takes base and a signed exponent; in_ready is high only
// while no word is in work. The output channel presents result and
// no_inverse until out_ready takes them; a stalled receiver holds the block.
// All products go through one multiplier that sums four half-width partial
// products. One modular product costs three such products plus one
// correction step. Each exponent bit but the last takes a loop step and a
// squaring, plus a multiplication when the bit is set; the exponent loop
// starts after a base reduction and a start step.
// A negative exponent first runs extended Euclid on a bit-serial divider,
// then one division. Reset loads modulus 1, reciprocal 0 and shift 63 and
// returns to idle.
module modular_exponentiation_unit #(
	parameter int WORD_BITS = mexp_pkg::WORD_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [63:0]                          base,
	input  logic signed [63:0]                   exponent,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [63:0]                          result,
	output logic                                 no_inverse,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [mexp_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [63:0]                          cfg_data
);
	import mexp_pkg::*;

	localparam int W = WORD_BITS;

	st_t state_q, state_d;
	ret_t ret_q;

	logic [63:0]  mod_q, recip_q;
	logic [5:0]   shift_q;
	logic [W-1:0] m_w, v_w;
	logic [5:0]   s_w;

	logic [W-1:0] d_q, hi_q, lo_q, q1_q, q0_q, r_q, b_q, acc_q, res_q;
	logic [W-1:0] r0_q, r1_q, u0_q, u1_q, quo_q;
	logic [63:0]  mag_q, mag_in, mag_nx;
	logic         k_q, noinv_q, issued_q, neg_q;

	logic           mul_start, mul_done, div_start, div_done;
	logic [W-1:0]   mul_a, mul_b, div_n, div_d, div_q, div_r;
	logic [2*W-1:0] prod, base_sh;
	logic [W-1:0]   plo, phi;
	logic [W:0]     sum1;
	logic [W-1:0]   q1n, rt, rr, inv_w;
	logic           acc_w;

	assign m_w = mod_q[W-1:0];
	assign v_w = recip_q[W-1:0];
	assign s_w = (shift_q > 6'(W - 1)) ? 6'(W - 1) : shift_q;
	assign base_sh = (2*W)'(base[W-1:0]) << s_w;
	assign mag_in = exponent[63] ? 64'd0 - exponent : exponent;
	assign mag_nx = mag_q >> 1;
	assign plo = prod[W-1:0];
	assign phi = prod[2*W-1:W];
	assign sum1 = {1'b0, plo} + {1'b0, lo_q};
	assign q1n = phi + hi_q + W'(sum1[W]);
	assign rt = (r_q >= q0_q) ? r_q + d_q : r_q;
	assign rr = (rt >= d_q) ? rt - d_q : rt;
	assign inv_w = (k_q || div_r == '0) ? div_r : m_w - div_r;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q <= 64'd1;
			recip_q <= 64'd0;
			shift_q <= 6'd63;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_MODULUS: mod_q <= cfg_data;
				REG_RECIP: recip_q <= cfg_data;
				REG_SHIFT: shift_q <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		state_d = state_q;
		mul_a = '0;
		mul_b = '0;
		div_n = '0;
		div_d = '0;
		acc_w = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = (m_w <= W'(1)) ? ST_OUT : ST_RED1;
				end
			end
			ST_RED1: begin
				mul_a = v_w;
				mul_b = hi_q;
				if (mul_done) state_d = ST_RED2;
			end
			ST_RED2: begin
				mul_a = q1_q + W'(1);
				mul_b = d_q;
				if (mul_done) state_d = ST_RED3;
			end
			ST_RED3: begin
				unique case (ret_q)
					RET_BASE: state_d = neg_q ? ST_INV_CHK : ST_EXP_START;
					RET_ACC: state_d = (mag_nx != '0) ? ST_NMUL : ST_OUT;
					RET_SQR: state_d = ST_EXP_LOOP;
					default: state_d = ST_IDLE;
				endcase
			end
			ST_NMUL: begin
				mul_a = ((ret_q == RET_ACC) ? acc_q : b_q) >> s_w;
				mul_b = b_q;
				if (mul_done) state_d = ST_RED1;
			end
			ST_INV_CHK: begin
				if (r1_q != '0) begin
					state_d = ST_INV_DIV;
				end else begin
					state_d = (r0_q != W'(1)) ? ST_OUT : ST_INV_MOD;
				end
			end
			ST_INV_DIV: begin
				div_n = r0_q;
				div_d = r1_q;
				if (div_done) state_d = ST_INV_MUL;
			end
			ST_INV_MUL: begin
				mul_a = quo_q;
				mul_b = u1_q;
				if (mul_done) state_d = ST_INV_CHK;
			end
			ST_INV_MOD: begin
				div_n = u0_q;
				div_d = m_w;
				if (div_done) state_d = ST_EXP_START;
			end
			ST_EXP_START: begin
				state_d = (mag_q == '0 || b_q == '0) ? ST_OUT : ST_EXP_LOOP;
			end
			ST_EXP_LOOP: begin
				acc_w = mag_q[0];
				state_d = (mag_q[0] || mag_nx != '0) ? ST_NMUL : ST_OUT;
			end
			ST_OUT: begin
				if (out_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign mul_start = !issued_q && (state_q == ST_RED1 || state_q == ST_RED2 ||
		state_q == ST_NMUL || state_q == ST_INV_MUL);
	assign div_start = !issued_q && (state_q == ST_INV_DIV || state_q == ST_INV_MOD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			issued_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (mul_start || div_start) begin
				issued_q <= 1'b1;
			end else if (mul_done || div_done) begin
				issued_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				d_q <= m_w << s_w;
				hi_q <= base_sh[2*W-1:W];
				lo_q <= base_sh[W-1:0];
				mag_q <= mag_in;
				neg_q <= exponent[63];
				ret_q <= RET_BASE;
				res_q <= '0;
				noinv_q <= 1'b0;
			end
			ST_RED1: begin
				if (mul_done) begin
					q0_q <= sum1[W-1:0];
					q1_q <= q1n;
				end
			end
			ST_RED2: begin
				if (mul_done) r_q <= lo_q - plo;
			end
			ST_RED3: begin
				unique case (ret_q)
					RET_BASE: begin
						b_q <= rr;
						r0_q <= m_w;
						r1_q <= rr >> s_w;
						u0_q <= '0;
						u1_q <= W'(1);
						k_q <= 1'b0;
					end
					RET_ACC: begin
						acc_q <= rr;
						mag_q <= mag_nx;
						ret_q <= RET_SQR;
						res_q <= rr >> s_w;
					end
					RET_SQR: b_q <= rr;
					default: ;
				endcase
			end
			ST_NMUL: begin
				if (mul_done) begin
					hi_q <= phi;
					lo_q <= plo;
				end
			end
			ST_INV_CHK: begin
				if (r1_q == '0 && r0_q != W'(1)) noinv_q <= 1'b1;
			end
			ST_INV_DIV: begin
				if (div_done) begin
					quo_q <= div_q;
					r0_q <= r1_q;
					r1_q <= div_r;
				end
			end
			ST_INV_MUL: begin
				if (mul_done) begin
					u0_q <= u1_q;
					u1_q <= u0_q + plo;
					k_q <= !k_q;
				end
			end
			ST_INV_MOD: begin
				if (div_done) b_q <= inv_w << s_w;
			end
			ST_EXP_START: begin
				acc_q <= W'(1) << s_w;
				if (mag_q == '0) res_q <= W'(1);
			end
			ST_EXP_LOOP: begin
				if (acc_w) begin
					ret_q <= RET_ACC;
				end else begin
					mag_q <= mag_nx;
					ret_q <= RET_SQR;
					res_q <= acc_q >> s_w;
				end
			end
			ST_OUT: ;
			default: ;
		endcase
	end

	mexp_mul #(.WORD_BITS(W)) u_mul (
		.clk(clk),
		.arst_n(arst_n),
		.start(mul_start),
		.a(mul_a),
		.b(mul_b),
		.done(mul_done),
		.prod(prod)
	);

	mexp_div #(.WORD_BITS(W)) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.num(div_n),
		.den(div_d),
		.done(div_done),
		.quot(div_q),
		.rem(div_r)
	);

	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign result = 64'(res_q);
	assign no_inverse = noinv_q;
	assign cfg_ready = 1'b1;

endmodule
